>>> hdl/lmes_pkg.sv
// types, codes, constants and curve table for the led matrix effect sequencer
`default_nettype none

package lmes_pkg;

   localparam int ROWS         = 3;
   localparam int COLS         = 3;
   localparam int STATIC_TICKS = 10;

   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 7;

   localparam logic [2:0]  ALL_ROWS     = 3'((1 << ROWS) - 1);
   localparam logic [3:0]  STATIC_LIMIT = 4'(STATIC_TICKS);
   localparam logic [9:0]  SLOW_FADE_MS = 10'd500;
   localparam logic [9:0]  FAST_FADE_MS = 10'd200;
   localparam logic [6:0]  MAX_PERCENT  = 7'd100;

   typedef enum logic [2:0] {
      CMD_TICK       = 3'd0,
      CMD_ADVERTISE  = 3'd1,
      CMD_ADV_ALL    = 3'd2,
      CMD_CONNECTED  = 3'd3,
      CMD_TOGGLE     = 3'd4,
      CMD_LAYERS     = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_SLOW   = 2'd1,
      KIND_FAST   = 2'd2,
      KIND_STATIC = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      BULK_NONE = 2'd0,
      BULK_ZERO = 2'd1,
      BULK_DUTY = 2'd2
   } bulk_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_SET  = 2'd1,
      ACT_FADE = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      REG_BRIGHTNESS = 3'd0,
      REG_BACKLIGHT  = 3'd1,
      REG_ROW_SEL    = 3'd2,
      REG_COL_SEL    = 3'd3,
      REG_BT_ALLOW   = 3'd4,
      REG_LAYER_ALLOW = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] row;
      logic [1:0] col;
   } layer_pos_type;

   // highest set bit of the layer mask picks the matrix position
   function automatic layer_pos_type layer_pos(input logic [7:0] mask);
      layer_pos_type pos;
      pos = '{hit: 1'b0, row: 2'd0, col: 2'd0};
      for (int i = 0; i < 8; i++) begin
         if (mask[i]) begin
            pos.hit = 1'b1;
            pos.row = ((i / ROWS) > (ROWS - 1)) ? 2'(ROWS - 1) : 2'(i / ROWS);
            pos.col = 2'(i % COLS);
         end
      end
      return pos;
   endfunction

   // cie 1931 lightness curve, index saturates at 100
   function automatic logic [7:0] lightness(input logic [6:0] pct);
      logic [7:0] tbl [0:100];
      logic [6:0] idx;
      tbl = '{
         8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2, 8'd2, 8'd2, 8'd2,
         8'd3, 8'd3, 8'd3, 8'd4, 8'd4, 8'd5, 8'd5, 8'd5, 8'd6, 8'd6,
         8'd7, 8'd8, 8'd8, 8'd9, 8'd10, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14,
         8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd23, 8'd24, 8'd25,
         8'd27, 8'd28, 8'd30, 8'd31, 8'd33, 8'd34, 8'd36, 8'd38, 8'd40, 8'd42,
         8'd44, 8'd46, 8'd48, 8'd50, 8'd52, 8'd54, 8'd56, 8'd59, 8'd61, 8'd64,
         8'd66, 8'd69, 8'd72, 8'd75, 8'd77, 8'd80, 8'd83, 8'd87, 8'd90, 8'd93,
         8'd96, 8'd100, 8'd103, 8'd107, 8'd110, 8'd114, 8'd118, 8'd122, 8'd126,
         8'd130, 8'd134, 8'd138, 8'd142, 8'd147, 8'd151, 8'd156, 8'd161, 8'd165,
         8'd170, 8'd175, 8'd180, 8'd185, 8'd191, 8'd196, 8'd201, 8'd207, 8'd213,
         8'd218, 8'd224, 8'd230, 8'd236
      };
      idx = (pct > MAX_PERCENT) ? MAX_PERCENT : pct;
      return tbl[idx];
   endfunction

endpackage

`default_nettype wire

>>> hdl/led_matrix_effect_sequencer.sv
// led matrix effect sequencer: event decode, effect state and per-step led commands
//
//  channel  direction  fields
//  req_     in         tuser: cmd[2:0]; tdata: event_data[7:0]
//  rsp_     out        tdata: row_off_mask[2:0], columns_bulk[4:3], channel_action[6:5],
//                             channel_index[8:7], channel_target[16:9], fade_time_ms[26:17]
//  csr_     in         write enable, register index, write data
//
//  one request per cycle unless stalled; its response is registered on acceptance
//  the output register is the only stage: req_tready is high while it is empty or drained
//  a stalled response holds and blocks further requests
//  synchronous reset restores config, effect state and rsp_tvalid, no clearing pass
`default_nettype none

module led_matrix_effect_sequencer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [lmes_pkg::REQ_DATA_W-1:0]   req_tdata,   // event_data
   input  wire logic [lmes_pkg::REQ_USER_W-1:0]   req_tuser,   // cmd
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [lmes_pkg::RSP_DATA_W-1:0]        rsp_tdata,   // row_off_mask, columns_bulk,
                                                              // channel_action, channel_index,
                                                              // channel_target, fade_time_ms
   input  wire logic                              csr_we,
   input  wire logic [lmes_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [lmes_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lmes_pkg::*;

   // configuration
   logic [6:0] brightness_ff;
   logic       backlight_on_ff;
   logic [1:0] row_sel_ff;
   logic [1:0] col_sel_ff;
   logic       bt_allow_ff;
   logic       layer_allow_ff;

   // effect state
   kind_type   kind_ff, kind_in;
   logic [1:0] row_ff, row_in;
   logic [1:0] col_ff, col_in;
   logic       fade_dir_ff, fade_dir_in;
   logic [3:0] flash_cnt_ff, flash_cnt_in;
   logic       bt_on_ff, bt_on_in;
   logic [2:0] row_levels_ff, row_levels_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] o_rows_ff;
   bulk_type   o_bulk_ff, o_bulk_in;
   action_type o_act_ff, o_act_in;
   logic [1:0] o_ch_ff, o_ch_in;
   logic [7:0] o_target_ff, o_target_in;
   logic [9:0] o_time_ff, o_time_in;

   logic          accept;
   cmd_type       cmd;
   logic [7:0]    evt_data;
   layer_pos_type lpos;
   logic          has_new;
   kind_type      new_kind;
   logic [1:0]    new_row;
   logic [1:0]    new_col;
   kind_type      kind_mid;
   logic [3:0]    flash_mid;
   logic [2:0]    rows_mid;
   logic [7:0]    duty;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign evt_data   = req_tdata;
   assign lpos       = layer_pos(evt_data);
   assign duty       = lightness(brightness_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff   <= 7'd50;
         backlight_on_ff <= 1'b1;
         row_sel_ff      <= 2'd0;
         col_sel_ff      <= 2'd0;
         bt_allow_ff     <= 1'b1;
         layer_allow_ff  <= 1'b1;
      end else if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_BRIGHTNESS:  brightness_ff   <= csr_wdata;
            REG_BACKLIGHT:   backlight_on_ff <= csr_wdata[0];
            REG_ROW_SEL: begin
               if (32'(csr_wdata[1:0]) < ROWS) row_sel_ff <= csr_wdata[1:0];
            end
            REG_COL_SEL: begin
               if (32'(csr_wdata[1:0]) < COLS) col_sel_ff <= csr_wdata[1:0];
            end
            REG_BT_ALLOW:    bt_allow_ff     <= csr_wdata[0];
            REG_LAYER_ALLOW: layer_allow_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // event decode
   always_comb begin
      has_new  = 1'b0;
      new_kind = KIND_NONE;
      new_row  = 2'd0;
      new_col  = 2'd0;
      bt_on_in = bt_on_ff;
      case (cmd)
         CMD_ADVERTISE, CMD_ADV_ALL, CMD_CONNECTED: begin
            if (bt_allow_ff && bt_on_ff) begin
               has_new  = 1'b1;
               new_kind = (cmd == CMD_ADVERTISE) ? KIND_SLOW :
                          (cmd == CMD_ADV_ALL)   ? KIND_FAST : KIND_STATIC;
               new_row  = row_sel_ff;
               new_col  = col_sel_ff;
            end
         end
         CMD_TOGGLE: begin
            if (bt_allow_ff) bt_on_in = (evt_data != 8'd0);
         end
         CMD_LAYERS: begin
            if (layer_allow_ff && lpos.hit) begin
               has_new  = 1'b1;
               new_kind = KIND_STATIC;
               new_row  = lpos.row;
               new_col  = lpos.col;
            end
         end
         default: ;
      endcase
   end

   // effect start and tick
   always_comb begin
      o_bulk_in   = BULK_NONE;
      o_act_in    = ACT_NONE;
      o_ch_in     = 2'd0;
      o_target_in = 8'd0;
      o_time_in   = 10'd0;
      kind_mid    = kind_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      fade_dir_in = fade_dir_ff;
      flash_mid   = flash_cnt_ff;
      rows_mid    = row_levels_ff;

      if (has_new) begin
         if (kind_ff == KIND_NONE) begin
            rows_mid  = ALL_ROWS & ~(3'd1 << new_row);
            o_bulk_in = BULK_ZERO;
         end else begin
            if (row_ff != new_row)
               rows_mid = (row_levels_ff | (3'd1 << row_ff)) & ~(3'd1 << new_row) & ALL_ROWS;
            if (col_ff != new_col) o_bulk_in = BULK_ZERO;
         end
         kind_mid    = new_kind;
         row_in      = new_row;
         col_in      = new_col;
         fade_dir_in = 1'b0;
         if (new_kind == KIND_STATIC) flash_mid = 4'd0;
      end

      kind_in       = kind_mid;
      flash_cnt_in  = flash_mid;
      row_levels_in = rows_mid;

      if (kind_mid != KIND_NONE && duty != 8'd0) begin
         if (kind_mid == KIND_SLOW || kind_mid == KIND_FAST) begin
            o_act_in    = ACT_FADE;
            o_ch_in     = col_in;
            o_time_in   = (kind_mid == KIND_SLOW) ? SLOW_FADE_MS : FAST_FADE_MS;
            o_target_in = fade_dir_in ? 8'd0 : duty;
            fade_dir_in = !fade_dir_in;
         end else begin
            if (flash_mid == 4'd0) begin
               o_act_in    = ACT_SET;
               o_ch_in     = col_in;
               o_target_in = duty;
            end
            if (flash_mid >= STATIC_LIMIT) begin
               flash_cnt_in = 4'd0;
               kind_in      = KIND_NONE;
               if (backlight_on_ff) begin
                  row_levels_in = 3'd0;
                  o_bulk_in     = BULK_DUTY;
               end else begin
                  row_levels_in = ALL_ROWS;
                  o_bulk_in     = BULK_ZERO;
               end
            end else begin
               flash_cnt_in = flash_mid + 4'd1;
            end
         end
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff       <= KIND_NONE;
         row_ff        <= 2'd0;
         col_ff        <= 2'd0;
         fade_dir_ff   <= 1'b0;
         flash_cnt_ff  <= 4'd0;
         bt_on_ff      <= 1'b1;
         row_levels_ff <= 3'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            kind_ff       <= kind_in;
            row_ff        <= row_in;
            col_ff        <= col_in;
            fade_dir_ff   <= fade_dir_in;
            flash_cnt_ff  <= flash_cnt_in;
            bt_on_ff      <= bt_on_in;
            row_levels_ff <= row_levels_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         o_rows_ff   <= row_levels_in;
         o_bulk_ff   <= o_bulk_in;
         o_act_ff    <= o_act_in;
         o_ch_ff     <= o_ch_in;
         o_target_ff <= o_target_in;
         o_time_ff   <= o_time_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, o_time_ff, o_target_ff, o_ch_ff, o_act_ff, o_bulk_ff, o_rows_ff};

   a_idle_action_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && o_act_ff == ACT_NONE |-> o_ch_ff == 2'd0 && o_target_ff == 8'd0)
      else $error("response without channel action carries channel data");

   a_fade_time_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (o_act_ff == ACT_FADE) == (o_time_ff != 10'd0))
      else $error("fade time does not match channel action");

   a_flash_bounded: assert property (@(posedge clock) disable iff (reset)
      kind_ff == KIND_STATIC |-> flash_cnt_ff <= STATIC_LIMIT)
      else $error("static flash counter past its limit");

   a_restore_ends_effect: assert property (@(posedge clock) disable iff (reset)
      accept && o_bulk_in == BULK_DUTY |=> kind_ff == KIND_NONE && row_levels_ff == 3'd0)
      else $error("backlight restore left an effect active");

endmodule

`default_nettype wire
